/* hw/rtl/cr8_pkg.sv */
// Shared types and constants for the eight-way midpoint circle rasterizer.
// No dependencies; every other file in hw/rtl imports this package.

package cr8_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 2;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [OUT_BITS-1:0] out_coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  // Head of the command queue, front to back.
  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } cmd_t;

  // Back-end status: pop strobe and circle-in-progress flag.
  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t radius;
  } cfg_t;

endpackage

/* hw/rtl/cr8_if.sv */
// Valid/ready channel interfaces for the circle rasterizer.
// Depends on cr8_pkg for coordinate widths.

interface cr8_in_if;
  import cr8_pkg::*;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cr8_out_if;
  import cr8_pkg::*;
  logic       valid;
  logic       ready;
  out_coord_t pixel_x;
  out_coord_t pixel_y;
  logic       last;

  modport source (output valid, output pixel_x, output pixel_y, output last, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last, output ready);
endinterface

/* hw/rtl/circle_rasterizer_eight_way.sv */
// Top level of the eight-way midpoint circle rasterizer: APB registers,
// front-end command queue and back-end stepper. Depends on cr8_pkg, cr8_if,
// cr8_front and cr8_back.
//
//   channel  dir  handshake          payload
//   in_if    in   valid/ready        restart
//   out_if   out  valid/ready        pixel_x, pixel_y, last
//   apb      in   psel/penable/pready paddr, pwdata, pwrite -> prdata
//
// One transaction per cycle sustained while out_if is not stalled. A
// command waits in the queue until the output register can take it; a
// tick then leaves it, and its pixel is registered and offered on out_if.
// Rate is set by the combinational midpoint step and the output register.
// Reset (rst_ni low) empties the queue, clears the stepper and registers.
// A stalled output holds the pixel; the two-entry queue absorbs input until
// full, then in_if.ready drops.

module circle_rasterizer_eight_way
  import cr8_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cr8_in_if.sink               in_if,
  cr8_out_if.source            out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t       cfg_q;
  cmd_t       head;
  back_stat_t stat;
  logic       wr_en;
  reg_idx_e   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X: cfg_q.center_x <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: cfg_q.center_y <= pwdata[COORD_BITS-1:0];
        REG_RADIUS:   cfg_q.radius   <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = DATA_BITS'(cfg_q.center_x);
      REG_CENTER_Y: prdata = DATA_BITS'(cfg_q.center_y);
      REG_RADIUS:   prdata = DATA_BITS'(cfg_q.radius);
      default:      prdata = '0;
    endcase
  end

  cr8_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .pop_i  (stat.pop),
    .head_o (head)
  );

  cr8_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .stat_o (stat),
    .out_if (out_if)
  );

`ifndef SYNTHESIS
  a_tick_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop && head.cmd == CMD_TICK && stat.busy |=> out_if.valid)
    else $error("busy tick left the queue without producing a pixel");

  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop && head.cmd == CMD_RESTART |=> stat.busy)
    else $error("restart did not start a circle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.last |-> !stat.busy)
    else $error("last pixel shown while stepper still busy");
`endif

endmodule

/* hw/rtl/cr8_front.sv */
// Front end: accepts input transactions, classifies them into commands and
// buffers them in a short queue. Depends on cr8_pkg and cr8_if.

module cr8_front
  import cr8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cr8_in_if.sink     in_if,
  input  logic       pop_i,
  output cmd_t       head_o
);

  cmd_e                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;
  cmd_e                 cmd_in;

  assign in_if.ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = pop_i && (count_q != '0);
  assign cmd_in      = in_if.restart ? CMD_RESTART : CMD_TICK;

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? QPTR_BITS'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? QPTR_BITS'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = QCNT_BITS'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = QCNT_BITS'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* hw/rtl/cr8_back.sv */
// Back end: midpoint circle stepper with mirror selection and output register.
// Depends on cr8_pkg and cr8_if.

module cr8_back
  import cr8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       head_i,
  output back_stat_t stat_o,
  cr8_out_if.source  out_if
);

  coord_t     offset_x_q, offset_x_d;
  coord_t     offset_y_q, offset_y_d;
  dec_t       dec_q, dec_d;
  logic [2:0] mirror_q, mirror_d;
  logic       busy_q, busy_d;

  logic       out_valid_q, out_valid_d;
  out_coord_t pix_x_q, pix_y_q;
  logic       last_q;

  logic       can_take;
  logic       pop;
  logic       emit;
  logic       done;
  out_coord_t x_s, y_s, x_next, y_next;
  out_coord_t dx, dy;
  out_coord_t pix_x, pix_y;

  assign can_take = !out_valid_q || out_if.ready;
  assign pop      = head_i.valid && can_take;
  assign emit     = pop && (head_i.cmd == CMD_TICK) && busy_q;

  assign x_s = out_coord_t'({2'b00, offset_x_q});
  assign y_s = out_coord_t'({2'b00, offset_y_q});

  always_comb begin
    unique case (mirror_q)
      3'd0: begin dx = x_s;  dy = y_s;  end
      3'd1: begin dx = x_s;  dy = -y_s; end
      3'd2: begin dx = y_s;  dy = x_s;  end
      3'd3: begin dx = y_s;  dy = -x_s; end
      3'd4: begin dx = -x_s; dy = -y_s; end
      3'd5: begin dx = -y_s; dy = -x_s; end
      3'd6: begin dx = -x_s; dy = y_s;  end
      default: begin dx = -y_s; dy = x_s; end
    endcase
  end

  assign pix_x = out_coord_t'({2'b00, cfg_i.center_x}) + dx;
  assign pix_y = out_coord_t'({2'b00, cfg_i.center_y}) + dy;

  // Midpoint step after the eighth image; compare in signed width so a
  // stepped-below-zero y still ends the circle.
  always_comb begin
    x_next = x_s + out_coord_t'(1);
    y_next = (dec_q < 0) ? y_s : y_s - out_coord_t'(1);
    done   = !(x_next < y_next);
  end

  always_comb begin
    offset_x_d = offset_x_q;
    offset_y_d = offset_y_q;
    dec_d      = dec_q;
    mirror_d   = mirror_q;
    busy_d     = busy_q;
    if (pop && head_i.cmd == CMD_RESTART) begin
      offset_x_d = '0;
      offset_y_d = cfg_i.radius;
      dec_d      = dec_t'(1) - dec_t'({2'b00, cfg_i.radius});
      mirror_d   = '0;
      busy_d     = 1'b1;
    end else if (emit) begin
      if (mirror_q == 3'd7) begin
        offset_x_d = x_next[COORD_BITS-1:0];
        offset_y_d = y_next[COORD_BITS-1:0];
        if (dec_q < 0) begin
          dec_d = dec_q + (x_next <<< 1) + dec_t'(1);
        end else begin
          dec_d = dec_q + ((x_next - y_next) <<< 1) + dec_t'(1);
        end
        mirror_d = '0;
        busy_d   = !done;
      end else begin
        mirror_d = mirror_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      dec_q       <= '0;
      mirror_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      offset_x_q  <= offset_x_d;
      offset_y_q  <= offset_y_d;
      dec_q       <= dec_d;
      mirror_q    <= mirror_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q <= pix_x;
      pix_y_q <= pix_y;
      last_q  <= (mirror_q == 3'd7) && done;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.pixel_x = pix_x_q;
  assign out_if.pixel_y = pix_y_q;
  assign out_if.last    = last_q;

  assign stat_o.pop  = pop;
  assign stat_o.busy = busy_q;

endmodule

/* verif/tb.sv */
// Self-checking testbench for circle_rasterizer_eight_way: sends restart and tick
// commands, writes the APB registers, predicts every pixel and checks the output.
// Depends on cr8_pkg, cr8_if and the rasterizer RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cr8_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int BIG_RADIUS_TICKS = 48;
  localparam int MAX_PRINTS = 30;
  localparam coord_t COORD_MAX = '1;
  // first address past the register list
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR = 4'hC;

  typedef struct {
    out_coord_t px;
    out_coord_t py;
    logic       fin;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  cr8_in_if  in_if ();
  cr8_out_if out_if ();

  circle_rasterizer_eight_way u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: configuration and stepper copy
  coord_t     cfg_cx = '0;
  coord_t     cfg_cy = '0;
  coord_t     cfg_r = '0;
  coord_t     step_x = '0;
  coord_t     step_y = '0;
  int         dcsn = 0;
  logic [2:0] octant = '0;
  bit         drawing = 1'b0;

  pixel_t pixels_due[$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int cycle_no = 0;
  int hold_end = 0;

  int mismatches = 0;
  int items_done = 0;
  int cmds_sent = 0;
  int restarts_sent = 0;
  int pixels_checked = 0;
  int lasts_seen = 0;
  int settings_used = 0;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t MISMATCH: %s", $time, what);
  endtask

  function automatic void predict_cmd(cmd_e cmd);
    int x, y, dx, dy;
    pixel_t pix;
    if (cmd == CMD_RESTART) begin
      step_x = '0;
      step_y = cfg_r;
      dcsn = 1 - int'(cfg_r);
      octant = '0;
      drawing = 1'b1;
      items_done++;
      restarts_sent++;
      return;
    end
    if (!drawing) return;
    items_done++;
    x = int'(step_x);
    y = int'(step_y);
    case (octant)
      3'd0: begin dx = x;  dy = y;  end
      3'd1: begin dx = x;  dy = -y; end
      3'd2: begin dx = y;  dy = x;  end
      3'd3: begin dx = y;  dy = -x; end
      3'd4: begin dx = -x; dy = -y; end
      3'd5: begin dx = -y; dy = -x; end
      3'd6: begin dx = -x; dy = y;  end
      default: begin dx = -y; dy = x; end
    endcase
    pix.fin = 1'b0;
    if (octant == 3'd7) begin
      x++;
      if (dcsn < 0) begin
        dcsn += 2 * x + 1;
      end else begin
        y--;
        dcsn += 2 * (x - y) + 1;
      end
      step_x = x[COORD_BITS-1:0];
      step_y = y[COORD_BITS-1:0];
      octant = '0;
      if (x >= y) begin
        drawing = 1'b0;
        pix.fin = 1'b1;
      end
    end else begin
      octant++;
    end
    // center is taken as it stands now; writes only happen with nothing in flight
    pix.px = OUT_BITS'(int'(cfg_cx) + dx);
    pix.py = OUT_BITS'(int'(cfg_cy) + dy);
    pixels_due.push_back(pix);
  endfunction

  task automatic send_cmd(cmd_e cmd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= cmd;
    do @(posedge clk_i); while (!in_if.ready);
    cmds_sent++;
    predict_cmd(cmd);
  endtask

  // all results in, plus slack for commands that produce none
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write, then read the same address back
  task automatic cfg_write(input logic [ADDR_BITS-1:0] addr, input coord_t val);
    logic [DATA_BITS-1:0] word;
    logic [DATA_BITS-1:0] want;
    word = $urandom;
    word[COORD_BITS-1:0] = val;
    want = '0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx_e'(addr[ADDR_BITS-1:2]))
      REG_CENTER_X: begin cfg_cx = val; want = DATA_BITS'(val); end
      REG_CENTER_Y: begin cfg_cy = val; want = DATA_BITS'(val); end
      REG_RADIUS:   begin cfg_r = val;  want = DATA_BITS'(val); end
      default: ;
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("read of address %0h: got %0h, want %0h",
                                addr, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_circle(input coord_t cx, input coord_t cy, input coord_t r);
    cfg_write({REG_CENTER_X, 2'b00}, cx);
    cfg_write({REG_CENTER_Y, 2'b00}, cy);
    cfg_write({REG_RADIUS, 2'b00}, r);
    if ($urandom_range(3) == 0) cfg_write(SPARE_ADDR, coord_t'($urandom_range(COORD_MAX)));
    settings_used++;
  endtask

  task automatic set_idling(input int send_pct, input int stall);
    sender_idle_pct = send_pct;
    stall_pct = stall;
  endtask

  // ticks to the circle's end (plus up to two more), the cap, or an early cut
  task automatic trace_circle(input int cap);
    int n;
    int stop_at;
    stop_at = ($urandom_range(9) == 0) ? int'($urandom_range(1, 60)) : cap;
    n = 0;
    while (drawing && n < stop_at) begin
      send_cmd(CMD_TICK);
      n++;
    end
    if (!drawing) repeat ($urandom_range(0, 2)) send_cmd(CMD_TICK);
  endtask

  task automatic test_idle_ticks();
    set_idling(0, 0);
    send_cmd(CMD_TICK);
    // registers still at reset: radius zero at the origin
    send_cmd(CMD_RESTART);
    repeat (8) send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
    wait_idle();
  endtask

  task automatic test_extremes();
    set_idling(23, 23);
    set_circle(COORD_MAX, COORD_MAX, 12'd1);
    cfg_write(SPARE_ADDR, coord_t'($urandom_range(COORD_MAX)));
    send_cmd(CMD_RESTART);
    repeat (8) send_cmd(CMD_TICK);
    wait_idle();
    set_circle(COORD_MAX, COORD_MAX, COORD_MAX);
    send_cmd(CMD_RESTART);
    repeat (5) send_cmd(CMD_TICK);
    // restart in the middle of an octant group
    send_cmd(CMD_RESTART);
    repeat (3) send_cmd(CMD_TICK);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    set_circle(12'd2048, 12'd1024, 12'd90);
    send_cmd(CMD_RESTART);
    hold_end = cycle_no + HOLD_CYCLES;
    repeat (40) send_cmd(CMD_TICK);
    wait_idle();
  endtask

  task automatic random_phase(input int mode);
    int     sel;
    int     circles;
    coord_t r;
    coord_t cx;
    coord_t cy;
    case (mode)
      0: set_idling(0, 0);
      1: set_idling(68, 0);
      2: set_idling(0, 68);
      default: set_idling(23, 23);
    endcase
    wait_idle();
    sel = int'($urandom_range(15));
    if (sel == 0) r = COORD_MAX;
    else if (sel == 1) r = coord_t'($urandom_range(65, COORD_MAX));
    else if (sel < 5) r = coord_t'($urandom_range(0, 3));
    else r = coord_t'($urandom_range(4, 30));
    cx = coord_t'($urandom_range(COORD_MAX));
    cy = coord_t'($urandom_range(COORD_MAX));
    if ($urandom_range(3) == 0) cx = $urandom_range(1) ? COORD_MAX : 12'd0;
    if ($urandom_range(3) == 0) cy = $urandom_range(1) ? COORD_MAX : 12'd0;
    set_circle(cx, cy, r);
    // an open circle resumes with the new center; new radius waits for restart
    if (drawing && $urandom_range(1)) trace_circle(BIG_RADIUS_TICKS);
    circles = int'($urandom_range(1, 3));
    repeat (circles) begin
      send_cmd(CMD_RESTART);
      trace_circle((r > 64) ? BIG_RADIUS_TICKS : 1 << 20);
    end
  endtask

  task automatic test_random();
    int first;
    int phase;
    first = items_done;
    phase = 0;
    while (items_done - first < RANDOM_ITEMS) begin
      random_phase(phase % 4);
      phase++;
    end
    wait_idle();
  endtask

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= (cycle_no >= hold_end) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                  out_if.pixel_x, out_if.pixel_y, out_if.last));
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (out_if.last === 1'b1) lasts_seen++;
        if (out_if.pixel_x !== want.px || out_if.pixel_y !== want.py ||
            out_if.last !== want.fin)
          report_mismatch($sformatf("pixel %0d: got (%0d,%0d) last=%0b, want (%0d,%0d) last=%0b",
                                    pixels_checked, out_if.pixel_x, out_if.pixel_y,
                                    out_if.last, want.px, want.py, want.fin));
      end
    end
  end

  initial begin : main
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    $display("Summary: %0d commands (%0d restarts, %0d live) gave %0d pixels, %0d ends,",
             cmds_sent, restarts_sent, items_done, pixels_checked, lasts_seen);
    $display("         over %0d register settings, four idle/stall mixes and a %0d-cycle hold.",
             settings_used, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** circle_rasterizer_eight_way: PASSED **");
    end else begin
      $display("** circle_rasterizer_eight_way: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d pixels outstanding", pixels_due.size());
    $display("** circle_rasterizer_eight_way: FAILED **");
    $finish;
  end

endmodule
